// File: design/pcm_pkg.sv
package pcm_pkg;

  // default widths for the usage fields and the wait counter
  localparam int USAGE_WIDTH_DEF = 8;
  localparam int WAIT_WIDTH_DEF  = 16;

  // fixed register widths
  localparam int LIMIT_W    = 8;
  localparam int CODE_W     = 3;
  localparam int PCT_W      = 7;
  localparam int INTERVAL_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GBR_PRB_LIMIT   = 3'd0,
    REG_BANDWIDTH_CODE  = 3'd1,
    REG_HIGH_MARGIN_PCT = 3'd2,
    REG_LOW_MARGIN_PCT  = 3'd3,
    REG_FULL_LIMIT      = 3'd4,
    REG_PREEMPT_WAIT    = 3'd5
  } cfg_idx_t;

  // cell bandwidth codes
  typedef enum logic [CODE_W-1:0] {
    BW_6_PRB   = 3'd0,
    BW_15_PRB  = 3'd1,
    BW_25_PRB  = 3'd2,
    BW_50_PRB  = 3'd3,
    BW_75_PRB  = 3'd4,
    BW_100_PRB = 3'd5
  } bw_code_t;

  // register reset values
  localparam logic [LIMIT_W-1:0]    GBR_PRB_LIMIT_RST = 8'd0;
  localparam logic [CODE_W-1:0]     BANDWIDTH_RST     = 3'd5;
  localparam logic [PCT_W-1:0]      HIGH_MARGIN_RST   = 7'd10;
  localparam logic [PCT_W-1:0]      LOW_MARGIN_RST    = 7'd5;
  localparam logic [LIMIT_W-1:0]    FULL_LIMIT_RST    = 8'd100;
  localparam logic [INTERVAL_W-1:0] PREEMPT_WAIT_RST  = 16'd5;

  // floor(cell_prbs * pct / 100) by shifts and small reciprocal multiplies
  //   6 prb  : floor(floor(3*pct/2) / 25), /25 as *41 >> 10
  //   15 prb : floor(floor(3*pct/4) / 5),  /5  as *205 >> 10
  //   undefined codes behave as 100 prbs
  function automatic logic [PCT_W-1:0] prb_margin(input logic [CODE_W-1:0] code,
                                                  input logic [PCT_W-1:0] pct);
    logic [8:0]  triple;
    logic [15:0] prod;
    logic [PCT_W-1:0] res;
    triple = {2'b00, pct} + {1'b0, pct, 1'b0};
    prod   = 16'd0;
    unique case (code)
      BW_6_PRB: begin
        prod = 16'(triple[8:1]) * 16'd41;
        res  = {1'b0, prod[15:10]};
      end
      BW_15_PRB: begin
        prod = 16'(triple[8:2]) * 16'd205;
        res  = {1'b0, prod[15:10]};
      end
      BW_25_PRB:  res = {2'b00, pct[PCT_W-1:2]};
      BW_50_PRB:  res = {1'b0, pct[PCT_W-1:1]};
      BW_75_PRB:  res = triple[8:2];
      default:    res = pct;
    endcase
    return res;
  endfunction

endpackage

// File: design/prb_congestion_monitor.sv
// GBR PRB congestion monitor
// Input channel: one transaction per check tick carrying the instantaneous
// and windowed DL/UL GBR PRB usage (in_valid / in_stall).
// Output channel: one transaction per input transaction with the congested
// flag after the tick and a preempt request (out_valid / out_stall).
// Config port: cfg_we, cfg_index and cfg_wdata write one register per cycle;
// write only while no tick is in flight.
// Path from input accept to out_valid: an input register, then the threshold
// compare and state update feeding the output register.
// Throughput: 1 transaction per cycle while out_stall is low; the congestion
// state is updated in the same cycle as the compare: no bubble between ticks.
// Stall: while the output register holds an untaken result and out_stall is
// high, a tick in the input register holds there and in_stall is high.
// Reset (rst_n low, synchronous): pipeline emptied, not congested, previous
// usages and wait counter cleared, registers back to their defaults.
module prb_congestion_monitor #(
  parameter int USAGE_WIDTH = pcm_pkg::USAGE_WIDTH_DEF,
  parameter int WAIT_WIDTH  = pcm_pkg::WAIT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // config write port
  input  logic                            cfg_we,
  input  logic [pcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [USAGE_WIDTH-1:0]          in_now_dl_usage,
  input  logic [USAGE_WIDTH-1:0]          in_now_ul_usage,
  input  logic [USAGE_WIDTH-1:0]          in_window_dl_usage,
  input  logic [USAGE_WIDTH-1:0]          in_window_ul_usage,
  // output channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_congested,
  output logic                            out_preempt_bearer
);

  localparam int CMP_W = (USAGE_WIDTH > pcm_pkg::LIMIT_W) ? USAGE_WIDTH : pcm_pkg::LIMIT_W;
  localparam int CNT_CMP_W = (WAIT_WIDTH > pcm_pkg::INTERVAL_W) ? WAIT_WIDTH
                                                                  : pcm_pkg::INTERVAL_W;

  // config registers
  logic [pcm_pkg::LIMIT_W-1:0]    gbr_prb_limit_r;
  logic [pcm_pkg::CODE_W-1:0]     bandwidth_code_r;
  logic [pcm_pkg::PCT_W-1:0]      high_margin_pct_r;
  logic [pcm_pkg::PCT_W-1:0]      low_margin_pct_r;
  logic [pcm_pkg::LIMIT_W-1:0]    full_limit_r;
  logic [pcm_pkg::INTERVAL_W-1:0] preempt_wait_r;

  // input register
  logic                   s1_valid_r;
  logic [USAGE_WIDTH-1:0] s1_now_dl_r;
  logic [USAGE_WIDTH-1:0] s1_now_ul_r;
  logic [USAGE_WIDTH-1:0] s1_win_dl_r;
  logic [USAGE_WIDTH-1:0] s1_win_ul_r;

  // monitor state
  logic                   congested_r, congested_nxt;
  logic [USAGE_WIDTH-1:0] prev_dl_r, prev_dl_nxt;
  logic [USAGE_WIDTH-1:0] prev_ul_r, prev_ul_nxt;
  logic [WAIT_WIDTH-1:0]  wait_cnt_r, wait_cnt_nxt;

  // output register
  logic out_valid_r;
  logic out_congested_r;
  logic out_preempt_r;

  logic advance;
  logic in_accept;
  logic preempt_nxt;

  logic [pcm_pkg::PCT_W-1:0]   hi_margin;
  logic [pcm_pkg::PCT_W-1:0]   lo_margin;
  logic [pcm_pkg::LIMIT_W:0]   hi_sum;
  logic [pcm_pkg::LIMIT_W-1:0] hi_thr;
  logic [pcm_pkg::LIMIT_W-1:0] lo_diff;
  logic [pcm_pkg::LIMIT_W-1:0] lo_thr;
  logic [CMP_W-1:0]            hi_cmp, lo_cmp;
  logic [CMP_W-1:0]            now_dl_cmp, now_ul_cmp;
  logic [WAIT_WIDTH-1:0]       wait_inc;
  logic [CNT_CMP_W-1:0]        wait_inc_cmp, interval_cmp;

  // handshake
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gbr_prb_limit_r   <= pcm_pkg::GBR_PRB_LIMIT_RST;
      bandwidth_code_r  <= pcm_pkg::BANDWIDTH_RST;
      high_margin_pct_r <= pcm_pkg::HIGH_MARGIN_RST;
      low_margin_pct_r  <= pcm_pkg::LOW_MARGIN_RST;
      full_limit_r      <= pcm_pkg::FULL_LIMIT_RST;
      preempt_wait_r    <= pcm_pkg::PREEMPT_WAIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcm_pkg::REG_GBR_PRB_LIMIT:   gbr_prb_limit_r   <= cfg_wdata[pcm_pkg::LIMIT_W-1:0];
        pcm_pkg::REG_BANDWIDTH_CODE:  bandwidth_code_r  <= cfg_wdata[pcm_pkg::CODE_W-1:0];
        pcm_pkg::REG_HIGH_MARGIN_PCT: high_margin_pct_r <= cfg_wdata[pcm_pkg::PCT_W-1:0];
        pcm_pkg::REG_LOW_MARGIN_PCT:  low_margin_pct_r  <= cfg_wdata[pcm_pkg::PCT_W-1:0];
        pcm_pkg::REG_FULL_LIMIT:      full_limit_r      <= cfg_wdata[pcm_pkg::LIMIT_W-1:0];
        pcm_pkg::REG_PREEMPT_WAIT:    preempt_wait_r    <= cfg_wdata[pcm_pkg::INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  // input register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_now_dl_r <= in_now_dl_usage;
      s1_now_ul_r <= in_now_ul_usage;
      s1_win_dl_r <= in_window_dl_usage;
      s1_win_ul_r <= in_window_ul_usage;
    end
  end

  // thresholds from the current register values
  always_comb begin
    hi_margin = pcm_pkg::prb_margin(bandwidth_code_r, high_margin_pct_r);
    lo_margin = pcm_pkg::prb_margin(bandwidth_code_r, low_margin_pct_r);
    hi_sum    = {1'b0, gbr_prb_limit_r} + (pcm_pkg::LIMIT_W+1)'(hi_margin);
    hi_thr    = (hi_sum > {1'b0, full_limit_r}) ? full_limit_r
                                                : hi_sum[pcm_pkg::LIMIT_W-1:0];
    lo_diff   = gbr_prb_limit_r - pcm_pkg::LIMIT_W'(lo_margin);
    if (pcm_pkg::LIMIT_W'(lo_margin) > gbr_prb_limit_r || lo_diff > full_limit_r) begin
      lo_thr = '0;
    end else begin
      lo_thr = lo_diff;
    end
    hi_cmp     = CMP_W'(hi_thr);
    lo_cmp     = CMP_W'(lo_thr);
    now_dl_cmp = CMP_W'(s1_now_dl_r);
    now_ul_cmp = CMP_W'(s1_now_ul_r);
  end

  // congestion state update
  always_comb begin
    congested_nxt = congested_r;
    prev_dl_nxt   = prev_dl_r;
    prev_ul_nxt   = prev_ul_r;
    wait_cnt_nxt  = wait_cnt_r;
    preempt_nxt   = 1'b0;
    wait_inc      = wait_cnt_r + WAIT_WIDTH'(1);
    wait_inc_cmp  = CNT_CMP_W'(wait_inc);
    interval_cmp  = CNT_CMP_W'(preempt_wait_r);
    if (!congested_r) begin
      // entering congestion
      if (now_dl_cmp >= hi_cmp || now_ul_cmp >= hi_cmp) begin
        congested_nxt = 1'b1;
        prev_dl_nxt   = s1_win_dl_r;
        prev_ul_nxt   = s1_win_ul_r;
        preempt_nxt   = 1'b1;
      end
    end else begin
      if (s1_win_dl_r < prev_dl_r || s1_win_ul_r < prev_ul_r) begin
        // usage dropping: restart pacing, maybe leave congestion
        wait_cnt_nxt = '0;
        if (now_dl_cmp <= lo_cmp && now_ul_cmp <= lo_cmp) begin
          congested_nxt = 1'b0;
        end
      end else if (wait_inc_cmp >= interval_cmp) begin
        // pacing interval reached
        wait_cnt_nxt = '0;
        preempt_nxt  = 1'b1;
      end else begin
        wait_cnt_nxt = wait_inc;
      end
      prev_dl_nxt = s1_win_dl_r;
      prev_ul_nxt = s1_win_ul_r;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      congested_r <= 1'b0;
      prev_dl_r   <= '0;
      prev_ul_r   <= '0;
      wait_cnt_r  <= '0;
    end else if (advance) begin
      congested_r <= congested_nxt;
      prev_dl_r   <= prev_dl_nxt;
      prev_ul_r   <= prev_ul_nxt;
      wait_cnt_r  <= wait_cnt_nxt;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_congested_r <= congested_nxt;
      out_preempt_r   <= preempt_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_congested      = out_congested_r;
  assign out_preempt_bearer = out_preempt_r;

`ifndef NO_ASSERTIONS
  // a preempt request only comes with the congested flag set
  a_preempt_congested: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_preempt_r |-> out_congested_r)
    else $error("preempt reported while not congested");

  // entering congestion always issues a preempt transaction
  a_enter_preempt: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(congested_r) |-> out_valid_r && out_preempt_r && out_congested_r)
    else $error("congestion entered without preempt");

  // the monitor state only changes when a tick is processed
  a_state_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(congested_r) && $stable(wait_cnt_r))
    else $error("monitor state changed without a tick");
`endif

endmodule

// File: test/tb_prb_congestion_monitor.sv
`timescale 1ns / 1ps

module tb_prb_congestion_monitor;

  localparam int UW         = pcm_pkg::USAGE_WIDTH_DEF;
  localparam int WW         = pcm_pkg::WAIT_WIDTH_DEF;
  localparam int NUM_ROWS   = 17;
  localparam int NUM_PHASES = 12;
  localparam int PHASE_LEN  = 136;

  // one check tick as driven on the input channel
  typedef struct packed {
    logic [UW-1:0] now_dl;
    logic [UW-1:0] now_ul;
    logic [UW-1:0] win_dl;
    logic [UW-1:0] win_ul;
  } usage_tick_t;

  // flags returned for one tick
  typedef struct packed {
    logic congested;
    logic preempt;
  } tick_flags_t;

  // directed row: tick plus optional hand-written flags
  typedef struct packed {
    usage_tick_t tick;
    logic        known;
    tick_flags_t flags;
  } dir_row_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [pcm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pcm_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           in_valid;
  logic                           in_stall;
  logic [UW-1:0]                  in_now_dl_usage;
  logic [UW-1:0]                  in_now_ul_usage;
  logic [UW-1:0]                  in_window_dl_usage;
  logic [UW-1:0]                  in_window_ul_usage;
  logic                           out_valid;
  logic                           out_stall;
  logic                           out_congested;
  logic                           out_preempt_bearer;

  // register shadow
  logic [pcm_pkg::LIMIT_W-1:0]    gbr_limit;
  logic [pcm_pkg::CODE_W-1:0]     bw_code;
  logic [pcm_pkg::PCT_W-1:0]      high_pct;
  logic [pcm_pkg::PCT_W-1:0]      low_pct;
  logic [pcm_pkg::LIMIT_W-1:0]    full_cap;
  logic [pcm_pkg::INTERVAL_W-1:0] wait_interval;

  // congestion state shadow
  logic                  is_congested;
  logic [UW-1:0]         last_win_dl;
  logic [UW-1:0]         last_win_ul;
  logic [WW-1:0]         quiet_ticks;

  tick_flags_t           pending_flags[$];
  int unsigned           error_count;
  int unsigned           gap_odds;
  int unsigned           stall_odds;
  int unsigned           stall_left;
  dir_row_t              dir_rows [NUM_ROWS];

  prb_congestion_monitor u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_now_dl_usage    (in_now_dl_usage),
    .in_now_ul_usage    (in_now_ul_usage),
    .in_window_dl_usage (in_window_dl_usage),
    .in_window_ul_usage (in_window_ul_usage),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_congested      (out_congested),
    .out_preempt_bearer (out_preempt_bearer)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // watchdog
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // prb count of the cell, undefined codes act as 100
  function automatic int unsigned cell_prbs();
    case (bw_code)
      pcm_pkg::BW_6_PRB:  return 6;
      pcm_pkg::BW_15_PRB: return 15;
      pcm_pkg::BW_25_PRB: return 25;
      pcm_pkg::BW_50_PRB: return 50;
      pcm_pkg::BW_75_PRB: return 75;
      default:            return 100;
    endcase
  endfunction

  // high threshold, capped at the full limit
  function automatic int unsigned high_bound();
    int unsigned t;
    t = gbr_limit + (cell_prbs() * high_pct) / 100;
    return (t > full_cap) ? full_cap : t;
  endfunction

  // low threshold, zero on underflow or above the full limit
  function automatic int unsigned low_bound();
    int unsigned m;
    int unsigned t;
    m = (cell_prbs() * low_pct) / 100;
    if (m > gbr_limit) return 0;
    t = gbr_limit - m;
    return (t > full_cap) ? 0 : t;
  endfunction

  // advance the congestion state by one tick and return its flags
  function automatic tick_flags_t advance_congestion(input usage_tick_t t);
    tick_flags_t f;
    int unsigned bound;
    f.preempt = 1'b0;
    if (!is_congested) begin
      bound = high_bound();
      if (t.now_dl >= bound || t.now_ul >= bound) begin
        is_congested = 1'b1;
        last_win_dl  = t.win_dl;
        last_win_ul  = t.win_ul;
        f.preempt    = 1'b1;
      end
    end else begin
      if (t.win_dl < last_win_dl || t.win_ul < last_win_ul) begin
        quiet_ticks = '0;
        bound = low_bound();
        if (t.now_dl <= bound && t.now_ul <= bound) is_congested = 1'b0;
      end else begin
        quiet_ticks = quiet_ticks + 1'b1;
        if (quiet_ticks >= wait_interval) begin
          f.preempt   = 1'b1;
          quiet_ticks = '0;
        end
      end
      last_win_dl = t.win_dl;
      last_win_ul = t.win_ul;
    end
    f.congested = is_congested;
    return f;
  endfunction

  // value within +-2 of a threshold, clamped to the field range
  function automatic logic [UW-1:0] around(input int unsigned x);
    int v;
    v = int'(x) + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[UW-1:0];
  endfunction

  // window value that does not fall below the previous one
  function automatic logic [UW-1:0] hold_window(input logic [UW-1:0] prev);
    int unsigned v;
    v = ($urandom_range(0, 1) == 0) ? prev : prev + $urandom_range(0, 3);
    return (v > 255) ? 8'd255 : v[UW-1:0];
  endfunction

  // random tick, mostly shaped to cross thresholds and hold congestion
  function automatic usage_tick_t shape_tick();
    usage_tick_t t;
    int unsigned hi;
    int unsigned lo;
    int unsigned r;
    t  = usage_tick_t'($urandom);
    hi = high_bound();
    lo = low_bound();
    r  = $urandom_range(0, 99);
    if (!is_congested) begin
      if (r < 55) begin
        // push one side near the high threshold
        if ($urandom_range(0, 1) == 0) t.now_dl = around(hi);
        else t.now_ul = around(hi);
      end else if (r < 85 && hi > 0) begin
        t.now_dl = UW'($urandom_range(0, hi - 1));
        t.now_ul = UW'($urandom_range(0, hi - 1));
      end
    end else begin
      if (r < 72) begin
        t.win_dl = hold_window(last_win_dl);
        t.win_ul = hold_window(last_win_ul);
      end else if (r < 92) begin
        // drop one window side
        t.win_dl = last_win_dl;
        t.win_ul = last_win_ul;
        if (last_win_dl > 0 && ($urandom_range(0, 1) == 0 || last_win_ul == 0))
          t.win_dl = UW'($urandom_range(0, last_win_dl - 1));
        else if (last_win_ul > 0)
          t.win_ul = UW'($urandom_range(0, last_win_ul - 1));
        if (r < 86) begin
          t.now_dl = UW'($urandom_range(0, lo));
          t.now_ul = ($urandom_range(0, 3) == 0) ? around(lo) : UW'($urandom_range(0, lo));
        end
      end
    end
    return t;
  endfunction

  // drive one transaction, predict on acceptance; entered and left at negedge
  task automatic send_tick(input usage_tick_t t, input logic known, input tick_flags_t flags);
    tick_flags_t f;
    if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_now_dl_usage    <= t.now_dl;
    in_now_ul_usage    <= t.now_ul;
    in_window_dl_usage <= t.win_dl;
    in_window_ul_usage <= t.win_ul;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    f = advance_congestion(t);
    pending_flags.push_back(known ? flags : f);
    @(negedge clk);
  endtask

  // write one register; entered and left at negedge
  task automatic write_reg(input pcm_pkg::cfg_idx_t idx,
                           input logic [pcm_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      pcm_pkg::REG_GBR_PRB_LIMIT:   gbr_limit     = val[pcm_pkg::LIMIT_W-1:0];
      pcm_pkg::REG_BANDWIDTH_CODE:  bw_code       = val[pcm_pkg::CODE_W-1:0];
      pcm_pkg::REG_HIGH_MARGIN_PCT: high_pct      = val[pcm_pkg::PCT_W-1:0];
      pcm_pkg::REG_LOW_MARGIN_PCT:  low_pct       = val[pcm_pkg::PCT_W-1:0];
      pcm_pkg::REG_FULL_LIMIT:      full_cap      = val[pcm_pkg::LIMIT_W-1:0];
      pcm_pkg::REG_PREEMPT_WAIT:    wait_interval = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // stall the result channel in random bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 17);
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // compare each result transaction against the oldest prediction
  always @(posedge clk) begin
    tick_flags_t exp_f;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_flags.size() == 0) begin
        $display("%0t: unexpected result expected none actual congested=%0b preempt=%0b",
                 $time, out_congested, out_preempt_bearer);
        error_count = error_count + 1;
      end else begin
        exp_f = pending_flags.pop_front();
        if (out_congested !== exp_f.congested) begin
          $display("%0t: congested mismatch expected %0b actual %0b",
                   $time, exp_f.congested, out_congested);
          error_count = error_count + 1;
        end
        if (out_preempt_bearer !== exp_f.preempt) begin
          $display("%0t: preempt_bearer mismatch expected %0b actual %0b",
                   $time, exp_f.preempt, out_preempt_bearer);
          error_count = error_count + 1;
        end
      end
    end
  end

  // main sequence
  initial begin
    int unsigned lim_v;
    int unsigned code_v;
    int unsigned hp_v;
    int unsigned lp_v;
    int unsigned full_v;
    int unsigned ivl_v;
    int unsigned k;

    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = pcm_pkg::REG_GBR_PRB_LIMIT;
    cfg_wdata          = '0;
    in_valid           = 1'b0;
    in_now_dl_usage    = '0;
    in_now_ul_usage    = '0;
    in_window_dl_usage = '0;
    in_window_ul_usage = '0;
    out_stall          = 1'b0;
    stall_left         = 0;
    error_count        = 0;
    gap_odds           = 4;
    stall_odds         = 4;

    gbr_limit     = pcm_pkg::GBR_PRB_LIMIT_RST;
    bw_code       = pcm_pkg::BANDWIDTH_RST;
    high_pct      = pcm_pkg::HIGH_MARGIN_RST;
    low_pct       = pcm_pkg::LOW_MARGIN_RST;
    full_cap      = pcm_pkg::FULL_LIMIT_RST;
    wait_interval = pcm_pkg::PREEMPT_WAIT_RST;
    is_congested  = 1'b0;
    last_win_dl   = '0;
    last_win_ul   = '0;
    quiet_ticks   = '0;

    // reset defaults: high threshold 10, low threshold 0, interval 5
    dir_rows = '{
      '{'{8'd0,   8'd0,   8'd0,   8'd0},   1'b1, '{1'b0, 1'b0}},
      '{'{8'd9,   8'd9,   8'd5,   8'd5},   1'b1, '{1'b0, 1'b0}},
      '{'{8'd10,  8'd0,   8'd50,  8'd50},  1'b1, '{1'b1, 1'b1}},
      '{'{8'd255, 8'd255, 8'd50,  8'd50},  1'b1, '{1'b1, 1'b0}},
      '{'{8'd255, 8'd255, 8'd60,  8'd60},  1'b1, '{1'b1, 1'b0}},
      '{'{8'd128, 8'd7,   8'd60,  8'd60},  1'b0, '{1'b0, 1'b0}},
      '{'{8'd3,   8'd200, 8'd60,  8'd60},  1'b0, '{1'b0, 1'b0}},
      '{'{8'd255, 8'd255, 8'd60,  8'd60},  1'b1, '{1'b1, 1'b1}},
      '{'{8'd0,   8'd0,   8'd59,  8'd60},  1'b1, '{1'b0, 1'b0}},
      '{'{8'd0,   8'd255, 8'd0,   8'd0},   1'b1, '{1'b1, 1'b1}},
      '{'{8'd0,   8'd0,   8'd0,   8'd0},   1'b1, '{1'b1, 1'b0}},
      '{'{8'd0,   8'd0,   8'd255, 8'd255}, 1'b1, '{1'b1, 1'b0}},
      '{'{8'd0,   8'd0,   8'd255, 8'd254}, 1'b1, '{1'b0, 1'b0}},
      '{'{8'd255, 8'd0,   8'd255, 8'd255}, 1'b1, '{1'b1, 1'b1}},
      '{'{8'd1,   8'd0,   8'd254, 8'd255}, 1'b1, '{1'b1, 1'b0}},
      '{'{8'd0,   8'd1,   8'd253, 8'd255}, 1'b1, '{1'b1, 1'b0}},
      '{'{8'd0,   8'd0,   8'd0,   8'd0},   1'b1, '{1'b0, 1'b0}}
    };

    // synchronous reset
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rows
    for (int i = 0; i < NUM_ROWS; i++)
      send_tick(dir_rows[i].tick, dir_rows[i].known, dir_rows[i].flags);

    // random phases, each behind a fresh register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      // let every result drain before touching registers
      in_valid <= 1'b0;
      while (pending_flags.size() != 0) @(posedge clk);
      @(negedge clk);

      case (p)
        0: begin lim_v = 0;   code_v = 5; hp_v = 10;  lp_v = 5;   full_v = 100; ivl_v = 5;     end
        1: begin lim_v = 255; code_v = 0; hp_v = 0;   lp_v = 0;   full_v = 255; ivl_v = 1;     end
        2: begin lim_v = 50;  code_v = 6; hp_v = 127; lp_v = 127; full_v = 255; ivl_v = 0;     end
        3: begin lim_v = 200; code_v = 7; hp_v = 100; lp_v = 60;  full_v = 150; ivl_v = 65535; end
        4: begin lim_v = 30;  code_v = 1; hp_v = 50;  lp_v = 20;  full_v = 0;   ivl_v = 3;     end
        5: begin lim_v = 120; code_v = 4; hp_v = 40;  lp_v = 100; full_v = 255; ivl_v = 2;     end
        6: begin lim_v = 80;  code_v = 2; hp_v = 127; lp_v = 127; full_v = 90;  ivl_v = 7;     end
        7: begin lim_v = 10;  code_v = 3; hp_v = 20;  lp_v = 127; full_v = 200; ivl_v = 4;     end
        default: begin
          lim_v  = $urandom_range(0, 255);
          code_v = $urandom_range(0, 7);
          hp_v   = $urandom_range(0, 127);
          lp_v   = $urandom_range(0, 127);
          full_v = $urandom_range(0, 255);
          k      = $urandom_range(0, 3);
          ivl_v  = (k == 0) ? $urandom_range(0, 3) :
                   (k == 3) ? $urandom_range(0, 65535) : $urandom_range(1, 20);
        end
      endcase

      write_reg(pcm_pkg::REG_GBR_PRB_LIMIT,   lim_v[pcm_pkg::CFG_DATA_W-1:0]);
      write_reg(pcm_pkg::REG_BANDWIDTH_CODE,  code_v[pcm_pkg::CFG_DATA_W-1:0]);
      write_reg(pcm_pkg::REG_HIGH_MARGIN_PCT, hp_v[pcm_pkg::CFG_DATA_W-1:0]);
      write_reg(pcm_pkg::REG_LOW_MARGIN_PCT,  lp_v[pcm_pkg::CFG_DATA_W-1:0]);
      write_reg(pcm_pkg::REG_FULL_LIMIT,      full_v[pcm_pkg::CFG_DATA_W-1:0]);
      write_reg(pcm_pkg::REG_PREEMPT_WAIT,    ivl_v[pcm_pkg::CFG_DATA_W-1:0]);
      cfg_we <= 1'b0;

      // idling mix for this phase, none in the last one
      if (p == NUM_PHASES - 1) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        k          = $urandom_range(0, 2);
        gap_odds   = (k == 0) ? 0 : (k == 1) ? 4 : 12;
        k          = $urandom_range(0, 2);
        stall_odds = (k == 0) ? 0 : (k == 1) ? 4 : 12;
      end

      for (int n = 0; n < PHASE_LEN; n++)
        send_tick(shape_tick(), 1'b0, '0);
    end

    // drain and allow for the pipeline latency
    in_valid <= 1'b0;
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
